// File: rtl/ptcct_pkg.sv
// Shared types, codes and field widths of the per-thread core counter table.
package ptcct_pkg;

  // Default table geometry
  localparam int NUM_CORES_DEF   = 8;
  localparam int NUM_ENTRIES_DEF = 64;

  // Field widths
  localparam int CORE_W   = 3;
  localparam int ID_W     = 22;
  localparam int DELTA_W  = 32;
  localparam int SUM_W    = 64;
  localparam int CNT32_W  = 32;
  localparam int INDEX_W  = 6;
  localparam int CORE_XW  = 7;   // holds a core number up to the largest core count

  // Stream payload widths
  localparam int IN_DATA_W  = 176;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 352;
  localparam int OUT_USER_W = 3;

  typedef enum logic [1:0] {
    ACT_SAMPLE  = 2'd0,
    ACT_LATENCY = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_QUERY   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_CLEARED   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    RES_STATUS,
    RES_UPDATE,
    RES_LATENCY,
    RES_QUERY,
    RES_INSERT
  } res_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_CMP,
    S_CELL_RD,
    S_CELL_OP,
    S_INSERT,
    S_STAT
  } fsm_e;

  // Per-entry key record
  typedef struct packed {
    logic [ID_W-1:0]   thread;
    logic [ID_W-1:0]   process;
    logic [CORE_W-1:0] core;
  } key_t;

  // Per-entry, per-core counter record
  typedef struct packed {
    logic [SUM_W-1:0]   inst;
    logic [SUM_W-1:0]   req;
    logic [SUM_W-1:0]   elapsed;
    logic [CNT32_W-1:0] samples;
    logic [SUM_W-1:0]   lat;
    logic [CNT32_W-1:0] lat_samples;
  } cell_t;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      scan_rd;
    logic      idx_inc;
    logic      cell_rd;
    logic      ins_wr;
    logic      clear;
    logic      post;
    res_kind_e kind;
    status_e   code;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    action_e act;
    logic    core_bad;
    logic    empty;
    logic    full;
    logic    hit;
    logic    last;
    logic    sweep_last;
    logic    out_free;
  } dp_stat_t;

endpackage

// File: rtl/per_thread_core_counter_table_core.sv
// Top level of the per-thread, per-core profiling counter table.
// Each transfer in is one request (counter sample, latency sample, clear, query) and
// gives exactly one result transfer. Requests are handled one at a time; the key
// lookup walks the filled slots of the key memory in order, reading a slot's key in
// S_SCAN and comparing it in S_CMP. A new thread is inserted by writing every core's
// counters of the new slot, one per cycle, the last write waiting until the output
// register is free. A clear or an out-of-range core skips the lookup. A finished
// result waits in the output register while the next request is accepted.
module per_thread_core_counter_table_core #(
  parameter int NUM_CORES   = ptcct_pkg::NUM_CORES_DEF,
  parameter int NUM_ENTRIES = ptcct_pkg::NUM_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // core, process_id, thread_id, inst_delta, req_delta, elapsed_delta, latency_delta
  input  logic [ptcct_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // action
  input  logic [ptcct_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // entry_index, owner_process, last_core_used, inst_total, req_total, elapsed_total,
  // sample_count, latency_total, latency_count
  output logic [ptcct_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [ptcct_pkg::OUT_USER_W-1:0] m_axis_tuser
);
  import ptcct_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer
  ptcct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic
  ptcct_dp #(
    .NUM_CORES   (NUM_CORES),
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );
endmodule

// File: rtl/ptcct_ctrl.sv
// Sequencer of lookup, update, insert and clear for the counter table.
module ptcct_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ptcct_pkg::dp_stat_t  stat_i,
  output ptcct_pkg::ctrl_cmd_t cmd_o
);
  import ptcct_pkg::*;

  fsm_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat_i.act == ACT_CLEAR || stat_i.core_bad) begin
          state_d = S_STAT;
        end else if (!stat_i.empty) begin
          state_d = S_SCAN;
        end else if (stat_i.act == ACT_SAMPLE && !stat_i.full) begin
          state_d = S_INSERT;
        end else begin
          state_d = S_STAT;
        end
      end
      S_SCAN: state_d = S_CMP;
      S_CMP: begin
        if (stat_i.hit) begin
          state_d = S_CELL_RD;
        end else if (!stat_i.last) begin
          state_d = S_SCAN;
        end else if (stat_i.act == ACT_SAMPLE && !stat_i.full) begin
          state_d = S_INSERT;
        end else begin
          state_d = S_STAT;
        end
      end
      S_CELL_RD: state_d = S_CELL_OP;
      S_CELL_OP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      S_INSERT: begin
        if (stat_i.sweep_last && stat_i.out_free) state_d = S_IDLE;
      end
      S_STAT: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = RES_STATUS;
    cmd_o.code = ST_NOT_FOUND;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_DISPATCH: ;
      S_SCAN: cmd_o.scan_rd = 1'b1;
      S_CMP: cmd_o.idx_inc = !stat_i.hit && !stat_i.last;
      S_CELL_RD: cmd_o.cell_rd = 1'b1;
      S_CELL_OP: begin
        cmd_o.post = stat_i.out_free;
        cmd_o.code = ST_UPDATED;
        priority if (stat_i.act == ACT_SAMPLE) begin
          cmd_o.kind = RES_UPDATE;
        end else if (stat_i.act == ACT_LATENCY) begin
          cmd_o.kind = RES_LATENCY;
        end else begin
          cmd_o.kind = RES_QUERY;
        end
      end
      S_INSERT: begin
        cmd_o.ins_wr = !stat_i.sweep_last || stat_i.out_free;
        cmd_o.post   = stat_i.sweep_last && stat_i.out_free;
        cmd_o.kind   = RES_INSERT;
        cmd_o.code   = ST_INSERTED;
      end
      S_STAT: begin
        cmd_o.post  = stat_i.out_free;
        cmd_o.clear = stat_i.out_free && stat_i.act == ACT_CLEAR;
        priority if (stat_i.act == ACT_CLEAR) begin
          cmd_o.code = ST_CLEARED;
        end else if (stat_i.core_bad) begin
          cmd_o.code = ST_NOT_FOUND;
        end else if (stat_i.act == ACT_SAMPLE && stat_i.full) begin
          cmd_o.code = ST_FULL;
        end else begin
          cmd_o.code = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  // Checks
  a_post_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.post |-> stat_i.out_free) else $error("result posted over a held result");
  a_scan_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |=> state_q == S_CMP) else $error("key compare skipped");
  a_ins_nofull : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_INSERT && state_d == S_INSERT) |-> !stat_i.full)
    else $error("insert into a full table");
endmodule

// File: rtl/ptcct_dp.sv
// Key and counter memories, item latch, adders and result register of the table.
module ptcct_dp #(
  parameter int NUM_CORES   = ptcct_pkg::NUM_CORES_DEF,
  parameter int NUM_ENTRIES = ptcct_pkg::NUM_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ptcct_pkg::ctrl_cmd_t             cmd_i,
  output ptcct_pkg::dp_stat_t              stat_o,
  input  logic [ptcct_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic [ptcct_pkg::IN_USER_W-1:0]  in_user_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [ptcct_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic [ptcct_pkg::OUT_USER_W-1:0] out_user_o
);
  import ptcct_pkg::*;

  localparam int SLOT_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(NUM_ENTRIES + 1);
  localparam int KIDX_W  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int CELLS   = NUM_ENTRIES * NUM_CORES;
  localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;

  // Latched item
  action_e              act_q;
  logic [CORE_W-1:0]    core_q;
  logic [ID_W-1:0]      pid_q, tid_q;
  logic [DELTA_W-1:0]   dinst_q, dreq_q, dela_q, dlat_q;

  // Control registers
  logic [CNT_W-1:0]     count_q;
  logic [SLOT_W-1:0]    idx_q;
  logic [KIDX_W-1:0]    k_q;
  logic                 out_valid_q;

  // Memories and their read registers
  key_t                 key_mem [NUM_ENTRIES];
  cell_t                cell_mem [CELLS];
  key_t                 key_rd_q;
  cell_t                cell_rd_q;

  logic [SLOT_W-1:0]    ins_slot;
  logic [CELL_AW-1:0]   hit_addr, ins_addr;
  logic [CORE_XW-1:0]   core_x;
  logic                 out_free;
  cell_t                upd_cell, ins_cell;
  logic [SLOT_W+INDEX_W-1:0] idx_wide, ins_wide;
  logic [INDEX_W-1:0]   res_index;
  logic [ID_W-1:0]      res_owner;
  logic [CORE_W-1:0]    res_core;
  cell_t                res_cell;
  status_e              res_code;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  assign core_x   = {{(CORE_XW-CORE_W){1'b0}}, core_q};
  assign ins_slot = count_q[SLOT_W-1:0];
  assign hit_addr = CELL_AW'(idx_q) * CELL_AW'(NUM_CORES) + CELL_AW'(core_q);
  assign ins_addr = CELL_AW'(ins_slot) * CELL_AW'(NUM_CORES) + CELL_AW'(k_q);
  assign out_free = !out_valid_q || out_ready_i;

  // Status to the controller
  always_comb begin
    stat_o.act        = act_q;
    stat_o.core_bad   = core_x >= CORE_XW'(NUM_CORES);
    stat_o.empty      = count_q == '0;
    stat_o.full       = count_q == CNT_W'(NUM_ENTRIES);
    stat_o.hit        = key_rd_q.thread == tid_q;
    stat_o.last       = CNT_W'(idx_q) + CNT_W'(1) == count_q;
    stat_o.sweep_last = k_q == KIDX_W'(NUM_CORES - 1);
    stat_o.out_free   = out_free;
  end

  // Latch the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= action_e'(in_user_i);
      core_q  <= in_data_i[2:0];
      pid_q   <= in_data_i[24:3];
      tid_q   <= in_data_i[46:25];
      dinst_q <= in_data_i[78:47];
      dreq_q  <= in_data_i[110:79];
      dela_q  <= in_data_i[142:111];
      dlat_q  <= in_data_i[174:143];
    end
  end

  // Scan index, sweep index, fill count, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
        k_q   <= '0;
      end else begin
        if (cmd_i.idx_inc) idx_q <= idx_q + SLOT_W'(1);
        if (cmd_i.ins_wr && !stat_o.sweep_last) k_q <= k_q + KIDX_W'(1);
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.post && cmd_i.kind == RES_INSERT) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.post) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Key memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.post && cmd_i.kind == RES_INSERT) begin
      key_mem[ins_slot] <= '{thread: tid_q, process: pid_q, core: core_q};
    end else if (cmd_i.post && cmd_i.kind == RES_UPDATE) begin
      key_mem[idx_q] <= '{thread: key_rd_q.thread, process: key_rd_q.process, core: core_q};
    end
    if (cmd_i.scan_rd) key_rd_q <= key_mem[idx_q];
  end

  // Accumulate into the hit cell
  always_comb begin
    upd_cell = cell_rd_q;
    if (cmd_i.kind == RES_UPDATE) begin
      upd_cell.inst    = cell_rd_q.inst + SUM_W'(dinst_q);
      upd_cell.req     = cell_rd_q.req + SUM_W'(dreq_q);
      upd_cell.elapsed = cell_rd_q.elapsed + SUM_W'(dela_q);
      upd_cell.samples = cell_rd_q.samples + CNT32_W'(1);
    end else if (cmd_i.kind == RES_LATENCY) begin
      upd_cell.lat         = cell_rd_q.lat + SUM_W'(dlat_q);
      upd_cell.lat_samples = cell_rd_q.lat_samples + CNT32_W'(1);
    end
  end

  // Fresh cell of a new entry: the sample's core gets the sample, others zero
  always_comb begin
    ins_cell = '0;
    if (CORE_XW'(k_q) == core_x) begin
      ins_cell.inst    = SUM_W'(dinst_q);
      ins_cell.req     = SUM_W'(dreq_q);
      ins_cell.elapsed = SUM_W'(dela_q);
      ins_cell.samples = CNT32_W'(1);
    end
  end

  // Counter memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_wr) begin
      cell_mem[ins_addr] <= ins_cell;
    end else if (cmd_i.post && (cmd_i.kind == RES_UPDATE || cmd_i.kind == RES_LATENCY)) begin
      cell_mem[hit_addr] <= upd_cell;
    end
    if (cmd_i.cell_rd) cell_rd_q <= cell_mem[hit_addr];
  end

  // Form the result
  assign idx_wide = {{INDEX_W{1'b0}}, idx_q};
  assign ins_wide = {{INDEX_W{1'b0}}, ins_slot};
  always_comb begin
    res_code  = cmd_i.code;
    res_index = '0;
    res_owner = '0;
    res_core  = '0;
    res_cell  = '0;
    unique case (cmd_i.kind)
      RES_STATUS: ;
      RES_INSERT: begin
        res_index = ins_wide[INDEX_W-1:0];
        res_owner = pid_q;
        res_core  = core_q;
        res_cell.inst    = SUM_W'(dinst_q);
        res_cell.req     = SUM_W'(dreq_q);
        res_cell.elapsed = SUM_W'(dela_q);
        res_cell.samples = CNT32_W'(1);
      end
      RES_UPDATE, RES_LATENCY, RES_QUERY: begin
        res_index = idx_wide[INDEX_W-1:0];
        res_owner = key_rd_q.process;
        res_core  = (cmd_i.kind == RES_UPDATE) ? core_q : key_rd_q.core;
        res_cell  = upd_cell;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.post) begin
      out_user_q <= res_code;
      out_data_q <= {1'b0, res_cell.lat_samples, res_cell.lat, res_cell.samples,
                     res_cell.elapsed, res_cell.req, res_cell.inst,
                     res_core, res_owner, res_index};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  // Checks
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(NUM_ENTRIES)) else $error("fill count beyond table size");
  a_scan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_rd |-> CNT_W'(idx_q) < count_q) else $error("scan past filled slots");
  a_one_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_wr |-> !(cmd_i.post && cmd_i.kind != RES_INSERT))
    else $error("two counter writes in one cycle");
endmodule
